// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and the sextet-to-character map of the base64 encoder ('+' for 62, '-' for 63)
`timescale 1ns / 1ps
package b64e_pkg;

  localparam int unsigned MaxChars = 4;
  localparam int unsigned CharW    = 7;
  localparam int unsigned CntW     = 3;

  localparam logic [CharW-1:0] PadChar  = 7'h3D;
  localparam logic [CharW-1:0] PlusChar = 7'h2B;
  localparam logic [CharW-1:0] DashChar = 7'h2D;

  localparam logic [1:0] PhaseFirst  = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird  = 2'd2;

  typedef logic [CharW-1:0] char_t;

  typedef struct packed {
    char_t [MaxChars-1:0] chars;
    logic  [CntW-1:0]     cnt;
    logic                 fin;
  } item_chars_t;

  function automatic char_t sextet_char(input logic [5:0] v);
    char_t c;
    c = {1'b0, v};
    if (v < 6'd26) begin
      return c + 7'd65;
    end else if (v < 6'd52) begin
      return c + 7'd71;
    end else if (v < 6'd62) begin
      return c - 7'd4;
    end else if (v == 6'd62) begin
      return PlusChar;
    end
    return DashChar;
  endfunction

endpackage

// ===== rtl/base64_stream_encoder_unit.sv =====
// Top level of the streaming base64 encoder: byte items in, character items out
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid in_ready in_data_byte in_final_byte  | into block
//   out     | out_valid out_ready out_char out_end_of_text  | out of block
//
// An accepted item is encoded in the same cycle into one to four characters.
// The first lands in the output register if it is free, else in the four-entry queue; the rest are queued.
// in_ready is high whenever the queue is empty, so an item may be taken while
// the output register still waits; an item yields one or two characters, or
// up to four for a final byte.
// Synchronous active-low reset empties the queue and output and starts a new group.
`timescale 1ns / 1ps
module base64_stream_encoder_unit
  import b64e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_end_of_text
);

  logic [1:0]  phase_r, phase_nxt, enc_phase;
  logic [3:0]  carry_r, carry_nxt, enc_carry;
  item_chars_t enc_item;

  char_t [MaxChars-1:0] q_char_r, q_char_nxt;
  logic  [MaxChars-1:0] q_eot_r, q_eot_nxt;
  logic  [CntW-1:0]     q_cnt_r, q_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  char_t       out_char_r, out_char_nxt;
  logic        out_eot_r, out_eot_nxt;

  logic                 accept, out_free;
  logic [MaxChars-1:0]  item_eot;

  b64e_group_enc u_enc (
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .phase      (phase_r),
    .carry      (carry_r),
    .item       (enc_item),
    .phase_nxt  (enc_phase),
    .carry_nxt  (enc_carry)
  );

  assign in_ready = (q_cnt_r == '0);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    for (int i = 0; i < MaxChars; i++) begin
      item_eot[i] = enc_item.fin && (CntW'(i) == enc_item.cnt - CntW'(1));
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    carry_nxt     = carry_r;
    q_char_nxt    = q_char_r;
    q_eot_nxt     = q_eot_r;
    q_cnt_nxt     = q_cnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_eot_nxt   = out_eot_r;

    if (accept) begin
      phase_nxt = enc_phase;
      carry_nxt = enc_carry;
      if (out_free) begin
        // first character straight to the output, remainder queued
        out_valid_nxt = 1'b1;
        out_char_nxt  = enc_item.chars[0];
        out_eot_nxt   = item_eot[0];
        for (int i = 0; i < MaxChars - 1; i++) begin
          q_char_nxt[i] = enc_item.chars[i+1];
          q_eot_nxt[i]  = item_eot[i+1];
        end
        q_cnt_nxt = enc_item.cnt - CntW'(1);
      end else begin
        q_char_nxt = enc_item.chars;
        q_eot_nxt  = item_eot;
        q_cnt_nxt  = enc_item.cnt;
      end
    end else if (out_free) begin
      if (q_cnt_r != '0) begin
        // advance the queue by one
        out_valid_nxt = 1'b1;
        out_char_nxt  = q_char_r[0];
        out_eot_nxt   = q_eot_r[0];
        for (int i = 0; i < MaxChars - 1; i++) begin
          q_char_nxt[i] = q_char_r[i+1];
          q_eot_nxt[i]  = q_eot_r[i+1];
        end
        q_cnt_nxt = q_cnt_r - CntW'(1);
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PhaseFirst;
      carry_r     <= '0;
      q_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      carry_r     <= carry_nxt;
      q_cnt_r     <= q_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_char_r   <= q_char_nxt;
    q_eot_r    <= q_eot_nxt;
    out_char_r <= out_char_nxt;
    out_eot_r  <= out_eot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_end_of_text = out_eot_r;

  a_queue_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r != '0) |-> out_valid_r)
    else $error("queued characters while output register empty");

  a_final_clears_group: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_final_byte) |=> (phase_r == PhaseFirst && carry_r == '0))
    else $error("group state not cleared after final byte");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PhaseFirst) || (phase_r == PhaseSecond) || (phase_r == PhaseThird))
    else $error("unused group phase reached");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (q_cnt_r <= CntW'(MaxChars)))
    else $error("character queue overfilled");

endmodule

// ===== rtl/b64e_group_enc.sv =====
// Group encoder: one byte plus group state in, up to four characters and next state out
`timescale 1ns / 1ps
module b64e_group_enc
  import b64e_pkg::*;
(
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic [1:0]  phase,
  input  logic [3:0]  carry,
  output item_chars_t item,
  output logic [1:0]  phase_nxt,
  output logic [3:0]  carry_nxt
);

  always_comb begin
    item.chars = '{default: PadChar};
    item.fin   = final_byte;
    item.cnt   = CntW'(1);
    phase_nxt  = PhaseFirst;
    carry_nxt  = '0;
    case (phase)
      PhaseSecond: begin
        item.chars[0] = sextet_char({carry[1:0], data_byte[7:4]});
        carry_nxt     = data_byte[3:0];
        phase_nxt     = PhaseThird;
        if (final_byte) begin
          item.chars[1] = sextet_char({data_byte[3:0], 2'b00});
          item.cnt      = CntW'(3);
        end
      end
      PhaseThird: begin
        item.chars[0] = sextet_char({carry, data_byte[7:6]});
        item.chars[1] = sextet_char(data_byte[5:0]);
        item.cnt      = CntW'(2);
      end
      default: begin
        item.chars[0] = sextet_char(data_byte[7:2]);
        carry_nxt     = {2'b00, data_byte[1:0]};
        phase_nxt     = PhaseSecond;
        if (final_byte) begin
          item.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
          item.cnt      = CntW'(4);
        end
      end
    endcase
    if (final_byte) begin
      phase_nxt = PhaseFirst;
      carry_nxt = '0;
    end
  end

endmodule
